>>> hdl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants of the min tracking stack: controller states,
// status codes and the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int unsigned DEFAULT_DEPTH = 256;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic load_op;
		logic exec;
		logic load_top;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic need_load;
		logic out_free;
	} sts_t;

endpackage

>>> hdl/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mts_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer of the min tracking stack: accept, execute, reload the top entry
// after a pop when needed, and hand the result to the output register.
// ----------------------------------------------------------------------------
module mts_ctrl
	import mts_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_op = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.need_load ? S_LOAD : S_RESULT;
			end
			S_LOAD: begin
				cmd.load_top = 1'b1;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/mts_dp.sv
// ----------------------------------------------------------------------------
// mts_dp
// Datapath of the min tracking stack: entry count, cached top entry with its
// running minimum, entry RAM and the output register.
// ----------------------------------------------------------------------------
module mts_dp
	import mts_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = DEFAULT_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic                     kind,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] top_value,
	output logic signed [DATA_W-1:0] min_value,
	output logic                     is_empty,
	output logic [1:0]               status
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

	logic                     pop_q;
	logic signed [DATA_W-1:0] val_q;
	logic [CW-1:0]            count_q;
	logic signed [DATA_W-1:0] top_val_q;
	logic signed [DATA_W-1:0] top_min_q;
	status_t                  status_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_top_q;
	logic signed [DATA_W-1:0] out_min_q;
	logic                     out_empty_q;
	status_t                  out_status_q;

	logic                     is_full;
	logic                     is_zero;
	logic signed [DATA_W-1:0] new_min;
	logic [CW-1:0]            count_m2;
	logic                     ram_we;
	logic                     ram_re;
	logic [2*DATA_W-1:0]      ram_rdata;

	assign is_full  = (count_q == FULL_COUNT);
	assign is_zero  = (count_q == '0);
	assign new_min  = (is_zero || (val_q < top_min_q)) ? val_q : top_min_q;
	assign count_m2 = count_q - CW'(2);
	assign ram_we   = cmd.exec && !pop_q && !is_full;
	assign ram_re   = cmd.exec && sts.need_load;

	assign sts.need_load = pop_q && (count_q > CW'(1));
	assign sts.out_free  = !out_valid_q || out_ready;

	mts_ram #(
		.WIDTH (2 * DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({new_min, val_q}),
		.re    (ram_re),
		.raddr (count_m2[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				if (!pop_q && !is_full) begin
					count_q <= count_q + CW'(1);
				end else if (pop_q && !is_zero) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			pop_q <= kind;
			val_q <= push_value;
		end
		if (cmd.exec) begin
			status_q <= ST_OK;
			if (!pop_q) begin
				if (is_full) begin
					status_q <= ST_PUSH_FULL;
				end else begin
					top_val_q <= val_q;
					top_min_q <= new_min;
				end
			end else if (is_zero) begin
				status_q <= ST_POP_EMPTY;
			end
		end
		if (cmd.load_top) begin
			top_val_q <= ram_rdata[DATA_W-1:0];
			top_min_q <= ram_rdata[2*DATA_W-1:DATA_W];
		end
		if (cmd.load_out) begin
			out_empty_q  <= is_zero;
			out_status_q <= status_q;
			out_top_q    <= is_zero ? '0 : top_val_q;
			out_min_q    <= is_zero ? '1 : top_min_q;
		end
	end

	assign out_valid = out_valid_q;
	assign top_value = out_top_q;
	assign min_value = out_min_q;
	assign is_empty  = out_empty_q;
	assign status    = out_status_q;

endmodule

>>> hdl/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded LIFO stack of signed 32-bit values that reports top and minimum.
// ----------------------------------------------------------------------------
// Each transfer on the input is a push (kind 0) or a pop (kind 1) and yields
// exactly one result: the new top (0 when empty), the minimum of the stored
// entries (-1 when empty), an empty flag and a status (ok, pop on empty
// ignored, push on full rejected). Every entry is stored with the running
// minimum at its push, and the top entry is kept in registers. After the
// input transfer an item passes through the EXEC and RESULT states into the
// output register; a pop that exposes an older entry also passes through
// the LOAD state, which takes the registered read data of the entry RAM
// into the top registers. A new input is taken as soon as the previous
// result sits in the output register, even while that result still waits
// for out_ready; a result that cannot enter the output register holds the
// input off until the waiting result is taken.
module min_tracking_stack
	import mts_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = DEFAULT_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] top_value,
	output logic signed [DATA_W-1:0] min_value,
	output logic                     is_empty,
	output logic [1:0]               status
);

	cmd_t cmd;
	sts_t sts;

	mts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mts_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.kind       (kind),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.top_value  (top_value),
		.min_value  (min_value),
		.is_empty   (is_empty),
		.status     (status)
	);

endmodule

>>> hdl/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks of the min tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
module mts_checker
	import mts_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     kind,
	input logic signed [DATA_W-1:0] push_value,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [DATA_W-1:0] top_value,
	input logic signed [DATA_W-1:0] min_value,
	input logic                     is_empty,
	input logic [1:0]               status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(top_value)
			&& $stable(min_value) && $stable(is_empty) && $stable(status))
		else $error("result changed while stalled");

	a_empty_values: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> top_value == '0 && min_value == '1)
		else $error("empty result with wrong top or minimum");

	a_min_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_empty |-> min_value <= top_value)
		else $error("minimum above top entry");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_POP_EMPTY |-> is_empty)
		else $error("pop on empty reported with entries");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an operation runs");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);
